FILE: hw/rtl/tdcp_pkg.sv
// ----------------------------------------------------------------------------
// tdcp_pkg
// Shared types and constants of the text display command port: command
// words, command sequencer states, status codes and the state record.
// ----------------------------------------------------------------------------
package tdcp_pkg;

  // command words written by the processor
  localparam logic [15:0] CMD_LOAD_BASE  = 16'h0001;
  localparam logic [15:0] CMD_SET_CURSOR = 16'h0002;
  localparam logic [15:0] CMD_ENABLE     = 16'h0003;
  localparam logic [15:0] CMD_ADVANCE    = 16'h0004;

  // item kinds on the command field
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // command sequencer, one-hot
  typedef enum logic [4:0] {
    SEQ_IDLE    = 5'b00001,
    SEQ_BASE    = 5'b00010,
    SEQ_CUR_COL = 5'b00100,
    SEQ_CUR_ROW = 5'b01000,
    SEQ_ENABLE  = 5'b10000
  } seq_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_AWAIT    = 2'd1,
    STAT_BAD_CMD  = 2'd2,
    STAT_BAD_ADDR = 2'd3
  } status_e;

  // architectural state of the port
  typedef struct packed {
    seq_e        seq;
    logic [15:0] first_arg;
    logic [15:0] col;
    logic [15:0] row;
    logic        cursor_on;
    logic        blink;
    logic [15:0] base;
    logic        base_loaded;
  } tdcp_state_t;

  // per-item report besides the state
  typedef struct packed {
    status_e status;
    logic    redraw;
  } tdcp_report_t;

endpackage

FILE: hw/rtl/tdcp_core.sv
// ----------------------------------------------------------------------------
// tdcp_core
// Command decode for one item: computes the next port state and the status
// and redraw request from the current state and the registered item.
// ----------------------------------------------------------------------------
module tdcp_core import tdcp_pkg::*; #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_LINES   = 25,
  parameter int SCREEN_WORDS = 2000
) (
  input  tdcp_state_t  state_i,
  input  logic         command_i,
  input  logic [15:0]  data_word_i,
  output tdcp_state_t  state_o,
  output tdcp_report_t report_o
);

  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic [16:0] base_end;
  logic        base_bad;

  // cursor advance arithmetic, computed without wrap
  assign col_inc  = {1'b0, state_i.col} + 17'd1;
  assign row_inc  = {1'b0, state_i.row} + 17'd1;
  // base range check: carry out means base plus screen exceeds 0xffff
  assign base_end = {1'b0, data_word_i} + 17'(SCREEN_WORDS);
  assign base_bad = base_end[16];

  // next state and report
  always_comb begin
    state_o  = state_i;
    report_o = '{status: STAT_DONE, redraw: 1'b0};

    if (command_i == KIND_TICK) begin
      state_o.blink   = ~state_i.blink;
      report_o.redraw = 1'b1;
      report_o.status = (state_i.seq != SEQ_IDLE) ? STAT_AWAIT : STAT_DONE;
    end else begin
      case (state_i.seq)
        SEQ_BASE: begin
          state_o.seq = SEQ_IDLE;
          if (base_bad) begin
            report_o.status = STAT_BAD_ADDR;
          end else begin
            state_o.base        = data_word_i;
            state_o.base_loaded = 1'b1;
            report_o.redraw     = 1'b1;
          end
        end
        SEQ_CUR_COL: begin
          state_o.first_arg = data_word_i;
          state_o.seq       = SEQ_CUR_ROW;
          report_o.status   = STAT_AWAIT;
        end
        SEQ_CUR_ROW: begin
          state_o.col = state_i.first_arg;
          state_o.row = data_word_i;
          state_o.seq = SEQ_IDLE;
        end
        SEQ_ENABLE: begin
          state_o.cursor_on = (data_word_i != 16'd0);
          state_o.seq       = SEQ_IDLE;
        end
        SEQ_IDLE: begin
          // decode a new command word
          case (data_word_i)
            CMD_LOAD_BASE: begin
              state_o.seq     = SEQ_BASE;
              report_o.status = STAT_AWAIT;
            end
            CMD_SET_CURSOR: begin
              state_o.seq     = SEQ_CUR_COL;
              report_o.status = STAT_AWAIT;
            end
            CMD_ENABLE: begin
              state_o.seq     = SEQ_ENABLE;
              report_o.status = STAT_AWAIT;
            end
            CMD_ADVANCE: begin
              if (col_inc >= 17'(TEXT_COLUMNS)) begin
                state_o.col = 16'd0;
                if (row_inc >= 17'(TEXT_LINES)) begin
                  state_o.row = 16'(TEXT_LINES - 1);
                end else begin
                  state_o.row = row_inc[15:0];
                end
              end else begin
                state_o.col = col_inc[15:0];
              end
            end
            default: begin
              report_o.status = STAT_BAD_CMD;
            end
          endcase
        end
        default: begin
          state_o.seq = SEQ_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/text_display_command_port_unit.sv
// ----------------------------------------------------------------------------
// text_display_command_port_unit
// Command front end of a text-mode display controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   command_i = 0 with a processor word on data_word_i, or command_i = 1 for
//   a blink tick. Words form commands: load base, set cursor, enable cursor,
//   advance cursor. Output channel (out_valid_o / out_stall_i) returns one
//   item per input item with cursor, base, status and redraw request.
//   An item transfers at a clock edge with valid high and stall low.
//   An accepted item passes through the input register, then the result
//   register, from which the receiver takes it. Throughput: one item per
//   cycle while the receiver does not stall; the state update is a single
//   pass of decode logic between the two registers.
//   Reset clears both stages, parks the cursor at column 0 row 0, disabled,
//   blink phase shown, base 0 and not loaded, no command pending.
//   When the receiver stalls, the result holds steady, the input register
//   keeps its item and in_stall_o rises while that register is occupied.
// ----------------------------------------------------------------------------
module text_display_command_port_unit import tdcp_pkg::*; #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_LINES   = 25,
  parameter int SCREEN_WORDS = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cursor_col_o,
  output logic [15:0] cursor_row_o,
  output logic        cursor_enabled_o,
  output logic        cursor_visible_o,
  output logic [15:0] video_base_o,
  output logic        base_valid_o,
  output logic [1:0]  status_o,
  output logic        redraw_o
);

  logic         in_valid_q;
  logic         cmd_q;
  logic [15:0]  word_q;
  logic         out_valid_q;
  logic         out_free;
  logic         advance;
  tdcp_state_t  state_q;
  tdcp_state_t  state_d;
  tdcp_report_t report_d;
  tdcp_report_t report_q;
  tdcp_state_t  shown_q;

  // handshake control
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q  <= command_i;
      word_q <= data_word_i;
    end
  end

  // command decode
  tdcp_core #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_LINES   (TEXT_LINES),
    .SCREEN_WORDS (SCREEN_WORDS)
  ) u_core (
    .state_i     (state_q),
    .command_i   (cmd_q),
    .data_word_i (word_q),
    .state_o     (state_d),
    .report_o    (report_d)
  );

  // port state, updated as each item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{seq: SEQ_IDLE, first_arg: 16'd0, col: 16'd0, row: 16'd0,
                   cursor_on: 1'b0, blink: 1'b1, base: 16'd0, base_loaded: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      shown_q  <= state_d;
      report_q <= report_d;
    end
  end

  // outputs
  assign out_valid_o      = out_valid_q;
  assign cursor_col_o     = shown_q.col;
  assign cursor_row_o     = shown_q.row;
  assign cursor_enabled_o = shown_q.cursor_on;
  assign cursor_visible_o = shown_q.blink;
  assign video_base_o     = shown_q.base;
  assign base_valid_o     = shown_q.base_loaded;
  assign status_o         = report_q.status;
  assign redraw_o         = report_q.redraw;

endmodule

FILE: bench/text_display_command_port_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_display_command_port_unit_tb
// Self-checking bench for the display command port. A behavioral copy of
// the command sequencer predicts the cursor, base, status and redraw of
// every accepted item. Received results are compared field by field in
// order. The stimulus runs directed corner cases first. Random command
// sequences follow, with random idling on both channels, one long
// receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module text_display_command_port_unit_tb;
  import tdcp_pkg::*;

  localparam int TEXT_COLUMNS   = 80;
  localparam int TEXT_LINES     = 25;
  localparam int SCREEN_WORDS   = 2000;
  localparam int LAST_GOOD_BASE = 16'hFFFF - SCREEN_WORDS;
  localparam int ITEM_TARGET    = 1150;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int SHOWN_ERRORS   = 10;
  localparam int HOLD_CYCLES    = 80;

  // one result of the port
  typedef struct {
    logic [15:0] col;
    logic [15:0] row;
    logic        enabled;
    logic        visible;
    logic [15:0] base;
    logic        base_ok;
    status_e     status;
    logic        redraw;
  } port_report_t;

  // predicts the port's reports and checks the received ones in order
  class port_report_scoreboard;
    seq_e         seq;
    logic [15:0]  held_col;
    logic [15:0]  col;
    logic [15:0]  row;
    logic         cursor_on;
    logic         blink;
    logic [15:0]  base;
    logic         base_ok;
    port_report_t awaited_reports[$];
    int unsigned  mismatches;

    function new();
      seq        = SEQ_IDLE;
      held_col   = '0;
      col        = '0;
      row        = '0;
      cursor_on  = 1'b0;
      blink      = 1'b1;
      base       = '0;
      base_ok    = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_reports.size();
    endfunction

    // advance the command state by one accepted item and queue its report
    function void note_item(logic kind, logic [15:0] word);
      port_report_t r;
      logic [16:0]  next_col;
      logic [16:0]  next_row;
      r.status = STAT_DONE;
      r.redraw = 1'b0;
      if (kind == KIND_TICK) begin
        // tick leaves any pending command alone
        blink    = ~blink;
        r.redraw = 1'b1;
        if (seq != SEQ_IDLE) r.status = STAT_AWAIT;
      end else begin
        case (seq)
          SEQ_BASE: begin
            seq = SEQ_IDLE;
            if (int'(word) > LAST_GOOD_BASE) begin
              r.status = STAT_BAD_ADDR;
            end else begin
              base     = word;
              base_ok  = 1'b1;
              r.redraw = 1'b1;
            end
          end
          SEQ_CUR_COL: begin
            held_col = word;
            seq      = SEQ_CUR_ROW;
            r.status = STAT_AWAIT;
          end
          SEQ_CUR_ROW: begin
            col = held_col;
            row = word;
            seq = SEQ_IDLE;
          end
          SEQ_ENABLE: begin
            cursor_on = (word != 16'h0000);
            seq       = SEQ_IDLE;
          end
          default: begin
            // whole word decoded as a command
            if (word == CMD_LOAD_BASE) begin
              seq      = SEQ_BASE;
              r.status = STAT_AWAIT;
            end else if (word == CMD_SET_CURSOR) begin
              seq      = SEQ_CUR_COL;
              r.status = STAT_AWAIT;
            end else if (word == CMD_ENABLE) begin
              seq      = SEQ_ENABLE;
              r.status = STAT_AWAIT;
            end else if (word == CMD_ADVANCE) begin
              // wrap the column, clamp the row
              next_col = {1'b0, col} + 17'd1;
              if (next_col >= TEXT_COLUMNS) begin
                col      = '0;
                next_row = {1'b0, row} + 17'd1;
                if (next_row >= TEXT_LINES) next_row = 17'(TEXT_LINES - 1);
                row = next_row[15:0];
              end else begin
                col = next_col[15:0];
              end
            end else begin
              r.status = STAT_BAD_CMD;
            end
          end
        endcase
      end
      r.col     = col;
      r.row     = row;
      r.enabled = cursor_on;
      r.visible = blink;
      r.base    = base;
      r.base_ok = base_ok;
      awaited_reports.insert(awaited_reports.size(), r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_report(port_report_t got);
      port_report_t want;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("result with no item waiting: col %h row %h status %0d",
                   got.col, got.row, got.status);
        return;
      end
      want = awaited_reports[0];
      awaited_reports.delete(0);
      compare_field("cursor_col", want.col, got.col);
      compare_field("cursor_row", want.row, got.row);
      compare_field("cursor_enabled", 16'(want.enabled), 16'(got.enabled));
      compare_field("cursor_visible", 16'(want.visible), 16'(got.visible));
      compare_field("video_base", want.base, got.base);
      compare_field("base_valid", 16'(want.base_ok), 16'(got.base_ok));
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("redraw", 16'(want.redraw), 16'(got.redraw));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        command_i   = 1'b0;
  logic [15:0] data_word_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] cursor_col_o;
  logic [15:0] cursor_row_o;
  logic        cursor_enabled_o;
  logic        cursor_visible_o;
  logic [15:0] video_base_o;
  logic        base_valid_o;
  logic [1:0]  status_o;
  logic        redraw_o;

  port_report_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned gap_pct     = 20;
  int unsigned cycle_count = 0;
  bit          quiet_tail  = 1'b0;
  bit          hold_wanted = 1'b0;

  text_display_command_port_unit #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_LINES  (TEXT_LINES),
    .SCREEN_WORDS(SCREEN_WORDS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .data_word_i     (data_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_enabled_o(cursor_enabled_o),
    .cursor_visible_o(cursor_visible_o),
    .video_base_o    (video_base_o),
    .base_valid_o    (base_valid_o),
    .status_o        (status_o),
    .redraw_o        (redraw_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // reset, released once
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // offer one item, wait for the port to take it
  task automatic offer_item(input logic kind, input logic [15:0] word);
    if (items_sent % 100 == 0) gap_pct = pick_idle_pct();
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= kind;
    data_word_i <= word;
    // inputs are stable from the falling edge to the next rising edge
    do @(negedge clk_i); while (in_stall_o);
    sb.note_item(kind, word);
    @(posedge clk_i);
    items_sent++;
  endtask

  // argument word, sometimes preceded by a tick
  task automatic send_argument(input logic [15:0] word);
    if ($urandom_range(0, 99) < 8) offer_item(KIND_TICK, 16'($urandom));
    offer_item(KIND_WORD, word);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // load base, mostly in range, some at the boundary
      case ($urandom_range(0, 9))
        0:       arg_a = 16'(LAST_GOOD_BASE + $urandom_range(0, 1));
        1, 2:    arg_a = 16'($urandom);
        default: arg_a = 16'($urandom_range(0, LAST_GOOD_BASE));
      endcase
      offer_item(KIND_WORD, CMD_LOAD_BASE);
      send_argument(arg_a);
    end else if (pick < 45) begin
      // set cursor, mostly near the screen
      if ($urandom_range(0, 6) == 0) begin
        arg_a = 16'($urandom);
        arg_b = 16'($urandom);
      end else begin
        arg_a = 16'($urandom_range(0, TEXT_COLUMNS + 1));
        arg_b = 16'($urandom_range(0, TEXT_LINES + 1));
      end
      offer_item(KIND_WORD, CMD_SET_CURSOR);
      send_argument(arg_a);
      send_argument(arg_b);
    end else if (pick < 55) begin
      case ($urandom_range(0, 2))
        0:       arg_a = 16'h0000;
        1:       arg_a = 16'h0001;
        default: arg_a = 16'($urandom);
      endcase
      offer_item(KIND_WORD, CMD_ENABLE);
      send_argument(arg_a);
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 12)) offer_item(KIND_WORD, CMD_ADVANCE);
    end else if (pick < 88) begin
      offer_item(KIND_TICK, 16'($urandom));
    end else if (pick < 94) begin
      offer_item(KIND_WORD, 16'($urandom));
    end else begin
      // broken sequence: a command word lands as an argument
      case ($urandom_range(0, 2))
        0:       arg_a = CMD_LOAD_BASE;
        1:       arg_a = CMD_SET_CURSOR;
        default: arg_a = CMD_ENABLE;
      endcase
      case ($urandom_range(0, 3))
        0:       arg_b = CMD_LOAD_BASE;
        1:       arg_b = CMD_SET_CURSOR;
        2:       arg_b = CMD_ENABLE;
        default: arg_b = CMD_ADVANCE;
      endcase
      offer_item(KIND_WORD, arg_a);
      offer_item(KIND_WORD, arg_b);
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int unsigned burst;
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned cyc;
    burst     = 0;
    hold_left = 0;
    stall_pct = 20;
    cyc       = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 200 == 0) stall_pct = pick_idle_pct();
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor, sampled while outputs are stable
  always @(negedge clk_i) begin : result_monitor
    port_report_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.col     = cursor_col_o;
      got.row     = cursor_row_o;
      got.enabled = cursor_enabled_o;
      got.visible = cursor_visible_o;
      got.base    = video_base_o;
      got.base_ok = base_valid_o;
      got.status  = status_e'(status_o);
      got.redraw  = redraw_o;
      sb.check_report(got);
    end
  end

  // stimulus
  initial begin : stimulus
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // tick, invalid words and an advance straight after reset
    offer_item(KIND_TICK, 16'hA5A5);
    offer_item(KIND_WORD, 16'h0000);
    offer_item(KIND_WORD, 16'hFFFF);
    offer_item(KIND_WORD, 16'h0005);
    offer_item(KIND_WORD, CMD_ADVANCE);
    // base at the last legal address, then one past it
    offer_item(KIND_WORD, CMD_LOAD_BASE);
    offer_item(KIND_WORD, 16'(LAST_GOOD_BASE));
    offer_item(KIND_WORD, CMD_LOAD_BASE);
    offer_item(KIND_WORD, 16'(LAST_GOOD_BASE + 1));
    // tick while a base load waits for its address
    offer_item(KIND_WORD, CMD_LOAD_BASE);
    offer_item(KIND_TICK, 16'h5A5A);
    offer_item(KIND_WORD, 16'h0000);
    // cursor far off screen, tick between column and row, then advance
    offer_item(KIND_WORD, CMD_SET_CURSOR);
    offer_item(KIND_WORD, 16'hFFFF);
    offer_item(KIND_TICK, 16'hFFFF);
    offer_item(KIND_WORD, 16'hFFFF);
    offer_item(KIND_WORD, CMD_ADVANCE);
    // last cell of the screen, advance wraps and clamps
    offer_item(KIND_WORD, CMD_SET_CURSOR);
    offer_item(KIND_WORD, 16'(TEXT_COLUMNS - 1));
    offer_item(KIND_WORD, 16'(TEXT_LINES - 1));
    offer_item(KIND_WORD, CMD_ADVANCE);
    // enable with a nonzero flag, then disable
    offer_item(KIND_WORD, CMD_ENABLE);
    offer_item(KIND_WORD, 16'h8000);
    offer_item(KIND_WORD, CMD_ENABLE);
    offer_item(KIND_WORD, 16'h0000);

    // random command sequences
    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 400) begin
        hold_done   = 1'b1;
        hold_wanted = 1'b1;
      end
      if (!drain_done && items_sent >= 700) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.outstanding() != 0);
      end
      if (items_sent >= ITEM_TARGET - 100) quiet_tail = 1'b1;
      send_random_command();
    end

    // wait for the last results before the verdict
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: text_display_command_port_unit.f
hw/rtl/tdcp_pkg.sv
hw/rtl/tdcp_core.sv
hw/rtl/text_display_command_port_unit.sv
bench/text_display_command_port_unit_tb.sv
